// ===== src/lru_handle_cache_unit_macros.svh =====
// Assertion helpers for the handle cache.
// All of them sample on i_clk and are masked while i_rst_n is low.
`ifndef LRU_HANDLE_CACHE_UNIT_MACROS_SVH
`define LRU_HANDLE_CACHE_UNIT_MACROS_SVH

// Same-cycle implication.
`define LHC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define LHC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/lhc_pkg.sv =====
`timescale 1ns / 1ps

package lhc_pkg;

    localparam int HANDLE_BITS = 64;
    localparam int LIMIT_BITS  = 7;
    localparam int STAMP_BITS  = 48;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 7'd50;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_SET = 1'b1;

    // Per-array write enables into the entry store.
    typedef struct packed {
        logic key_we;
        logic handle_we;
        logic stamp_we;
    } t_wr_ctl;

endpackage

// ===== src/lru_handle_cache_unit.sv =====
`timescale 1ns / 1ps

// Fully associative key -> handle cache with least-recently-used replacement.
// Each beat on the input channel is a get (look up key, return its handle and
// mark it most recent) or a set (store the pair as most recent; an existing key
// has its handle replaced and the old one released if it differs; a new key at
// the configured limit evicts the least recently used entry and releases its
// handle). Exactly one result beat comes out per input beat. Only the low
// KEY_BITS bits of the key are stored and compared. An item occupies the block
// until its result is registered, plus any output stall: one shared read port
// walks every slot of the key/handle/stamp arrays, one slot per cycle, and a
// single compare unit checks key match, free slot and oldest use stamp as the
// slots go by; the last cycle writes the one slot that changes. Recency is kept
// as a per-slot use stamp from a 48-bit counter, the oldest entry being the
// valid one with the smallest stamp. Entry valid bits are reset flip-flops, so
// no clearing pass is needed. The user writes the limit register via the cfg
// channel (always ready) only while no item is in flight; the block does not
// enforce it. Zero acts as one, values above MAX_ENTRIES act as MAX_ENTRIES.
// Lowering the limit below the current fill does not shrink the cache. A
// finished result waits in the output register while the next item is accepted.

`include "lru_handle_cache_unit_macros.svh"

module lru_handle_cache_unit import lhc_pkg::*; #(
    parameter int MAX_ENTRIES = 64,
    parameter int KEY_BITS    = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input channel
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_command,
    input  logic [63:0]            i_key,
    input  logic [HANDLE_BITS-1:0] i_handle_in,
    // result channel
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_hit,
    output logic [HANDLE_BITS-1:0] o_handle_out,
    output logic                   o_released_valid,
    output logic [HANDLE_BITS-1:0] o_released_handle,
    // limit register write
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [LIMIT_BITS-1:0]  i_cfg_data
);

    localparam int AW   = $clog2(MAX_ENTRIES);
    localparam int CW   = $clog2(MAX_ENTRIES + 1);
    localparam int CMPW = (CW > LIMIT_BITS) ? CW : LIMIT_BITS;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]             r_state, n_state;
    logic [LIMIT_BITS-1:0]  r_limit;

    // captured item
    logic                   r_cmd;
    logic [KEY_BITS-1:0]    r_key;
    logic [HANDLE_BITS-1:0] r_hin;

    // scan pipeline: address issued, then checked in the next cycle
    logic [AW-1:0]          r_idx;
    logic                   r_chk_vld;
    logic [AW-1:0]          r_chk_idx;

    // scan findings
    logic                   r_found;
    logic [AW-1:0]          r_slot;
    logic [HANDLE_BITS-1:0] r_hit_handle;
    logic                   r_have_old;
    logic [AW-1:0]          r_old_slot;
    logic [STAMP_BITS-1:0]  r_old_stamp;
    logic [HANDLE_BITS-1:0] r_old_handle;
    logic                   r_have_free;
    logic [AW-1:0]          r_free_slot;

    logic [MAX_ENTRIES-1:0] r_valid;
    logic [CW-1:0]          r_count;
    logic [STAMP_BITS-1:0]  r_now;

    // output register
    logic                   r_out_valid;
    logic                   r_hit;
    logic [HANDLE_BITS-1:0] r_handle_out;
    logic                   r_rel_valid;
    logic [HANDLE_BITS-1:0] r_rel_handle;

    // store read side
    logic [KEY_BITS-1:0]    key_rd;
    logic [HANDLE_BITS-1:0] handle_rd;
    logic [STAMP_BITS-1:0]  stamp_rd;

    logic                   accept_in;
    logic                   out_free;
    logic                   do_done;
    logic                   slot_v;
    logic                   match;
    logic                   older;
    logic                   free_hit;

    logic [CMPW-1:0]        lim_ext;
    logic [CMPW-1:0]        eff_limit;
    logic                   room;

    t_wr_ctl                wr_ctl;
    t_wr_ctl                wr_gated;
    logic [AW-1:0]          wr_addr;
    logic                   set_valid;
    logic                   count_inc;
    logic                   res_hit;
    logic [HANDLE_BITS-1:0] res_hout;
    logic                   res_rel;
    logic [HANDLE_BITS-1:0] res_rhandle;

    assign accept_in   = i_in_valid && (r_state == ST_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign do_done     = (r_state == ST_DONE) && out_free;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    assign o_out_valid       = r_out_valid;
    assign o_hit             = r_hit;
    assign o_handle_out      = r_handle_out;
    assign o_released_valid  = r_rel_valid;
    assign o_released_handle = r_rel_handle;

    lhc_store #(
        .DEPTH (MAX_ENTRIES),
        .KEY_W (KEY_BITS),
        .AW    (AW)
    ) u_store (
        .i_clk       (i_clk),
        .i_rd_addr   (r_idx),
        .o_key       (key_rd),
        .o_handle    (handle_rd),
        .o_stamp     (stamp_rd),
        .i_wr        (wr_gated),
        .i_wr_addr   (wr_addr),
        .i_wr_key    (r_key),
        .i_wr_handle (r_hin),
        .i_wr_stamp  (r_now)
    );

    // per-slot check on the data read back this cycle
    always_comb begin
        slot_v   = r_valid[r_chk_idx];
        match    = r_chk_vld && slot_v && (key_rd == r_key);
        older    = r_chk_vld && slot_v && (!r_have_old || (stamp_rd < r_old_stamp));
        free_hit = r_chk_vld && !slot_v && !r_have_free;
    end

    // effective limit: zero acts as one, clipped to the array depth
    always_comb begin
        lim_ext = CMPW'(r_limit);
        if (lim_ext == '0) begin
            eff_limit = CMPW'(1);
        end else if (lim_ext > CMPW'(MAX_ENTRIES)) begin
            eff_limit = CMPW'(MAX_ENTRIES);
        end else begin
            eff_limit = lim_ext;
        end
        room = CMPW'(r_count) < eff_limit;
    end

    // final decision and the one slot write
    always_comb begin
        wr_ctl      = '0;
        wr_addr     = r_slot;
        set_valid   = 1'b0;
        count_inc   = 1'b0;
        res_hit     = 1'b0;
        res_hout    = '0;
        res_rel     = 1'b0;
        res_rhandle = '0;
        if (r_cmd == CMD_GET) begin
            res_hit         = r_found;
            res_hout        = r_found ? r_hit_handle : '0;
            wr_ctl.stamp_we = r_found;
        end else if (r_found) begin
            // set on a present key: replace, promote
            res_hit          = 1'b1;
            res_rel          = (r_hit_handle != r_hin);
            res_rhandle      = res_rel ? r_hit_handle : '0;
            wr_ctl.handle_we = 1'b1;
            wr_ctl.stamp_we  = 1'b1;
        end else if (room) begin
            wr_addr   = r_free_slot;
            wr_ctl    = '{key_we: 1'b1, handle_we: 1'b1, stamp_we: 1'b1};
            set_valid = 1'b1;
            count_inc = 1'b1;
        end else begin
            // evict least recently used
            wr_addr     = r_old_slot;
            wr_ctl      = '{key_we: 1'b1, handle_we: 1'b1, stamp_we: 1'b1};
            res_rel     = 1'b1;
            res_rhandle = r_old_handle;
        end
        wr_gated = do_done ? wr_ctl : '0;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (accept_in) n_state = ST_SCAN;
            ST_SCAN:  if (r_idx == AW'(MAX_ENTRIES - 1)) n_state = ST_DRAIN;
            ST_DRAIN: n_state = ST_DONE;
            ST_DONE:  if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_limit     <= LIMIT_RESET;
            r_idx       <= '0;
            r_chk_vld   <= 1'b0;
            r_found     <= 1'b0;
            r_have_old  <= 1'b0;
            r_have_free <= 1'b0;
            r_valid     <= '0;
            r_count     <= '0;
            r_now       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_chk_vld <= (r_state == ST_SCAN);

            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end

            if (accept_in) begin
                r_idx       <= '0;
                r_found     <= 1'b0;
                r_have_old  <= 1'b0;
                r_have_free <= 1'b0;
            end else if (r_state == ST_SCAN) begin
                r_idx <= r_idx + AW'(1);
            end

            if (match && !r_found) begin
                r_found <= 1'b1;
            end
            if (older) begin
                r_have_old <= 1'b1;
            end
            if (free_hit) begin
                r_have_free <= 1'b1;
            end

            if (set_valid && do_done) begin
                r_valid[wr_addr] <= 1'b1;
            end
            if (count_inc && do_done) begin
                r_count <= r_count + CW'(1);
            end
            if (wr_gated.stamp_we) begin
                r_now <= r_now + STAMP_BITS'(1);
            end

            if (do_done) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_chk_idx <= r_idx;
        if (accept_in) begin
            r_cmd <= i_command;
            r_key <= i_key[KEY_BITS-1:0];
            r_hin <= i_handle_in;
        end
        if (match && !r_found) begin
            r_slot       <= r_chk_idx;
            r_hit_handle <= handle_rd;
        end
        if (older) begin
            r_old_slot   <= r_chk_idx;
            r_old_stamp  <= stamp_rd;
            r_old_handle <= handle_rd;
        end
        if (free_hit) begin
            r_free_slot <= r_chk_idx;
        end
        if (do_done) begin
            r_hit        <= res_hit;
            r_handle_out <= res_hout;
            r_rel_valid  <= res_rel;
            r_rel_handle <= res_rhandle;
        end
    end

    `LHC_ASSERT_NOW(a_count_tracks_valid, 1'b1, r_count == CW'($countones(r_valid)), "fill count differs from valid bits")
    `LHC_ASSERT_NOW(a_free_slot_known, (r_state == ST_DONE) && (r_cmd == CMD_SET) && !r_found && room, r_have_free, "insert with room but no free slot seen")
    `LHC_ASSERT_NOW(a_victim_known, (r_state == ST_DONE) && (r_cmd == CMD_SET) && !r_found && !room, r_have_old, "eviction with no valid entry seen")
    `LHC_ASSERT_NEXT(a_result_loaded, do_done, r_out_valid && (r_state == ST_IDLE), "finished item did not reach output register")

endmodule

// ===== src/lhc_store.sv =====
`timescale 1ns / 1ps

module lhc_store import lhc_pkg::*; #(
    parameter int DEPTH = 64,
    parameter int KEY_W = 64,
    parameter int AW    = 6
) (
    input  logic                   i_clk,
    input  logic [AW-1:0]          i_rd_addr,
    output logic [KEY_W-1:0]       o_key,
    output logic [HANDLE_BITS-1:0] o_handle,
    output logic [STAMP_BITS-1:0]  o_stamp,
    input  t_wr_ctl                i_wr,
    input  logic [AW-1:0]          i_wr_addr,
    input  logic [KEY_W-1:0]       i_wr_key,
    input  logic [HANDLE_BITS-1:0] i_wr_handle,
    input  logic [STAMP_BITS-1:0]  i_wr_stamp
);

    logic [KEY_W-1:0]       r_keys    [DEPTH];
    logic [HANDLE_BITS-1:0] r_handles [DEPTH];
    logic [STAMP_BITS-1:0]  r_stamps  [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr.key_we) begin
            r_keys[i_wr_addr] <= i_wr_key;
        end
        if (i_wr.handle_we) begin
            r_handles[i_wr_addr] <= i_wr_handle;
        end
        if (i_wr.stamp_we) begin
            r_stamps[i_wr_addr] <= i_wr_stamp;
        end
    end

    // registered read, one address for all three arrays
    always_ff @(posedge i_clk) begin
        o_key    <= r_keys[i_rd_addr];
        o_handle <= r_handles[i_rd_addr];
        o_stamp  <= r_stamps[i_rd_addr];
    end

endmodule
